FILE: rtl/ecsm_pkg.sv
package ecsm_pkg;

  localparam int unsigned FieldBits  = 31;
  localparam int unsigned ScalarBits = 32;
  localparam int unsigned CoefAReset = 2;
  localparam int unsigned ModReset   = 17;

  // Register indexes on the configuration port.
  localparam int unsigned RegCoefA   = 0;
  localparam int unsigned RegModulus = 1;

  typedef struct packed {
    logic [ScalarBits-1:0] scalar;
    logic                  point_at_infinity;
    logic [FieldBits-1:0]  point_y;
    logic [FieldBits-1:0]  point_x;
  } ecsm_in_t;

  typedef struct packed {
    logic                 inverse_fault;
    logic                 result_at_infinity;
    logic [FieldBits-1:0] result_y;
    logic [FieldBits-1:0] result_x;
  } ecsm_out_t;

  // Request and response between the sequencer and the field multiplier.
  typedef struct packed {
    logic start;
  } ecsm_mul_req_t;

  typedef struct packed {
    logic done;
  } ecsm_mul_rsp_t;

endpackage

FILE: rtl/ec_scalar_multiply_core.sv
// Affine elliptic-curve scalar multiplier, k*P by right-to-left
// double-and-add over a prime field of up to 31 bits. Drive start high with
// a transaction; it is taken at the rising edge where busy is low, and busy
// is high from the next cycle. The result strobe done_o lasts one cycle, comes
// with busy back low, and cannot be stalled: capture it then. A zero scalar,
// a base point at infinity or a modulus below three goes from acceptance
// straight to the output state, with no field product. Otherwise every
// field product runs through one bit-serial multiplier; a point operation
// costs up to 2*FIELD_BITS+5 products (the Fermat inversion always walks all
// FIELD_BITS exponent bits, squaring each and multiplying on set bits), and
// at most SCALAR_BITS doublings plus as many additions run. Each full
// computation writes coef_a back reduced modulo the modulus. Write coef_a
// (0x0) and modulus (0x4) only while idle.
module ec_scalar_multiply_core #(
  parameter int unsigned FIELD_BITS  = ecsm_pkg::FieldBits,
  parameter int unsigned SCALAR_BITS = ecsm_pkg::ScalarBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ecsm_pkg::ecsm_in_t  in_i,
  output logic                done_o,
  output ecsm_pkg::ecsm_out_t out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [FIELD_BITS-1:0] coef_a_q, mod_q;
  logic                  wr_en;
  logic                  coef_wr;
  logic [FIELD_BITS-1:0] coef_red;

  // Register file: two field-width registers.
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= FIELD_BITS'(ecsm_pkg::CoefAReset);
      mod_q    <= FIELD_BITS'(ecsm_pkg::ModReset);
    end else if (wr_en) begin
      if (paddr[2] == 1'(ecsm_pkg::RegCoefA)) coef_a_q <= pwdata[FIELD_BITS-1:0];
      else mod_q <= pwdata[FIELD_BITS-1:0];
    end else if (coef_wr) begin
      // Hold coef_a reduced once a computation has reduced it.
      coef_a_q <= coef_red;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(ecsm_pkg::RegModulus)) prdata[FIELD_BITS-1:0] = mod_q;
    else prdata[FIELD_BITS-1:0] = coef_a_q;
  end

  ecsm_seq #(.FIELD_BITS(FIELD_BITS), .SCALAR_BITS(SCALAR_BITS)) u_seq (
    .clk_i, .rst_ni, .start_i(start && !busy), .in_i,
    .coef_a_i(coef_a_q), .mod_i(mod_q),
    .busy_o(busy), .done_o, .out_o,
    .coef_wr_o(coef_wr), .coef_a_o(coef_red)
  );

`ifndef ASSERT_OFF
  // The result strobe comes with the return to idle.
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe without return to idle");
  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.inverse_fault |-> !out_o.result_at_infinity &&
    out_o.result_x == '0 && out_o.result_y == '0) else $error("fault result not cleared");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction not started");
`endif
endmodule

FILE: rtl/ecsm_fmul.sv
// Bit-serial modular multiplier: one doubling and conditional add per cycle.
module ecsm_fmul #(
  parameter int unsigned FIELD_BITS = ecsm_pkg::FieldBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ecsm_pkg::ecsm_mul_req_t  req_i,
  input  logic [FIELD_BITS-1:0]    a_i,
  input  logic [FIELD_BITS-1:0]    b_i,
  input  logic [FIELD_BITS-1:0]    mod_i,
  output ecsm_pkg::ecsm_mul_rsp_t  rsp_o,
  output logic [FIELD_BITS-1:0]    prod_o
);
  localparam int unsigned CntW = $clog2(FIELD_BITS + 1);

  logic [FIELD_BITS-1:0] acc_q, acc_d, b_q, b_d, a_q, a_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [FIELD_BITS:0]   dbl, dblr, sum;
  logic [FIELD_BITS-1:0] step;

  always_comb begin
    dbl  = {acc_q, 1'b0};
    dblr = (dbl >= {1'b0, mod_i}) ? dbl - {1'b0, mod_i} : dbl;
    sum  = dblr + {1'b0, a_q};
    if (b_q[FIELD_BITS-1]) begin
      step = (sum >= {1'b0, mod_i}) ? FIELD_BITS'(sum - {1'b0, mod_i})
                                    : FIELD_BITS'(sum);
    end else begin
      step = FIELD_BITS'(dblr);
    end
    acc_d = acc_q; b_d = b_q; a_d = a_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      acc_d = '0; a_d = a_i; b_d = b_i;
      cnt_d = CntW'(FIELD_BITS); busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = step;
      b_d = {b_q[FIELD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end

  assign rsp_o.done = done_q;
  assign prod_o = acc_q;
endmodule

FILE: rtl/ecsm_seq.sv
// Point arithmetic sequencer: double-and-add over scalar bits, all products
// and Fermat inversions through the shared multiplier.
module ecsm_seq #(
  parameter int unsigned FIELD_BITS  = ecsm_pkg::FieldBits,
  parameter int unsigned SCALAR_BITS = ecsm_pkg::ScalarBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  ecsm_pkg::ecsm_in_t      in_i,
  input  logic [FIELD_BITS-1:0]   coef_a_i,
  input  logic [FIELD_BITS-1:0]   mod_i,
  output logic                    busy_o,
  output logic                    done_o,
  output ecsm_pkg::ecsm_out_t     out_o,
  output logic                    coef_wr_o,
  output logic [FIELD_BITS-1:0]   coef_a_o
);
  localparam int unsigned CntW = $clog2(FIELD_BITS + 1);
  localparam int unsigned EW   = $clog2(FIELD_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_LOOP, S_ADD, S_DBL, S_CHK,
    S_PREP, S_INV_SQ, S_INV_SQW, S_INV_ML, S_INV_MLW,
    S_LAM, S_LAMW, S_LSQ, S_LSQW, S_YM, S_YMW,
    S_TSQ, S_TSQW, S_T3, S_T3W, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic [FIELD_BITS-1:0] a_q, m_q, qx_q, qy_q, rx_q, ry_q, t_q, num_q, den_q, inv_q,
                         xr_q, red_q;
  logic [SCALAR_BITS-1:0] mag_q;
  logic rinf_q, fault_q, dbl_q, is_dbl_q, res_inf_q, done_q;
  logic in_i_neg_q;
  logic [1:0] red_cnt_q;
  logic [CntW-1:0] bit_q;
  logic [FIELD_BITS-1:0] ma_q, mb_q;
  ecsm_pkg::ecsm_mul_req_t req_q;
  ecsm_pkg::ecsm_mul_rsp_t rsp;
  logic [FIELD_BITS-1:0] prod;
  ecsm_pkg::ecsm_out_t out_q;

  ecsm_fmul #(.FIELD_BITS(FIELD_BITS)) u_fmul (
    .clk_i, .rst_ni, .req_i(req_q), .a_i(ma_q), .b_i(mb_q), .mod_i(m_q),
    .rsp_o(rsp), .prod_o(prod)
  );

  function automatic logic [FIELD_BITS-1:0] fadd(
    input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
    input logic [FIELD_BITS-1:0] m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return FIELD_BITS'(s);
  endfunction

  function automatic logic [FIELD_BITS-1:0] fsub(
    input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
    input logic [FIELD_BITS-1:0] m);
    return (x >= y) ? x - y : m - (y - x);
  endfunction

  // Operands of the current point addition or doubling: p1 and p2.
  logic [FIELD_BITS-1:0] p1x, p1y, p2x, p2y;
  logic [FIELD_BITS-1:0] e_val;
  always_comb begin
    p1x = dbl_q ? qx_q : rx_q;
    p1y = dbl_q ? qy_q : ry_q;
    p2x = qx_q;
    p2y = qy_q;
    e_val = m_q - FIELD_BITS'(2);
  end

  // Launch a product whenever the state below loads new operands.
  logic mul_go;
  always_comb begin
    mul_go = 1'b0;
    case (state_q)
      S_RED:     mul_go = (red_cnt_q == 2'd0) || ((red_cnt_q != 2'd3) && rsp.done);
      S_CHK:     mul_go = is_dbl_q;
      S_TSQW, S_LAMW, S_LSQW: mul_go = rsp.done;
      S_INV_SQ:  mul_go = 1'b1;
      S_INV_SQW: mul_go = rsp.done && e_val[EW'(bit_q - 1'b1)];
      default:   mul_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      req_q.start <= mul_go;
      done_q <= (state_q == S_OUT);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            m_q <= mod_i; a_q <= coef_a_i;
            qx_q <= in_i.point_x; qy_q <= in_i.point_y;
            mag_q <= in_i.scalar[SCALAR_BITS-1] ? SCALAR_BITS'(-in_i.scalar)
                                                : in_i.scalar;
            in_i_neg_q <= in_i.scalar[SCALAR_BITS-1];
            fault_q <= (mod_i < FIELD_BITS'(3)); rinf_q <= 1'b1;
            res_inf_q <= 1'b0;
            if (mod_i < FIELD_BITS'(3)) begin
              state_q <= S_OUT;
            end else if (in_i.scalar == '0 || in_i.point_at_infinity) begin
              state_q <= S_OUT;
            end else begin
              red_q <= '0; red_cnt_q <= '0; state_q <= S_RED;
            end
          end
        end
        // Reduce a, x, y modulo p as the product 1*v: v runs through the
        // bit-serial path, so any W-bit value comes out fully reduced.
        // The reduced a also goes back to the coef_a register; y is negated for a negative scalar.
        S_RED: begin
          case (red_cnt_q)
            2'd0: begin ma_q <= FIELD_BITS'(1); mb_q <= a_q;
              red_cnt_q <= 2'd1; end
            2'd1: if (rsp.done) begin a_q <= prod; ma_q <= FIELD_BITS'(1);
              mb_q <= qx_q; red_cnt_q <= 2'd2; end
            2'd2: if (rsp.done) begin qx_q <= prod; ma_q <= FIELD_BITS'(1);
              mb_q <= qy_q; red_cnt_q <= 2'd3; end
            default: if (rsp.done) begin
              qy_q <= in_i_neg_q ? fsub('0, prod, m_q) : prod;
              state_q <= S_LOOP; end
          endcase
        end
        S_LOOP: begin
          if (mag_q == '0) state_q <= S_OUT;
          else if (mag_q[0]) begin dbl_q <= 1'b0; state_q <= S_ADD; end
          else begin dbl_q <= 1'b1; state_q <= S_DBL; end
        end
        S_ADD, S_DBL: begin
          // Resolve the cheap cases of the group law.
          if (!dbl_q && rinf_q) begin
            rx_q <= qx_q; ry_q <= qy_q; rinf_q <= 1'b0; state_q <= S_FIN;
          end else if (p1x == p2x && fadd(p1y, p2y, m_q) == '0) begin
            res_inf_q <= 1'b1; state_q <= S_FIN;
          end else begin
            res_inf_q <= 1'b0;
            is_dbl_q <= (p1x == p2x && p1y == p2y);
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (is_dbl_q) begin
            den_q <= fadd(p1y, p1y, m_q);
            ma_q <= p1x; mb_q <= p1x; state_q <= S_TSQW;
          end else begin
            num_q <= fsub(p2y, p1y, m_q);
            den_q <= fsub(p2x, p1x, m_q);
            state_q <= S_PREP;
          end
        end
        S_TSQW: if (rsp.done) begin
          ma_q <= prod; mb_q <= FIELD_BITS'(3);
          state_q <= S_T3W;
        end
        S_T3W: if (rsp.done) begin
          num_q <= fadd(prod, a_q, m_q); state_q <= S_PREP;
        end
        S_PREP: begin
          if (den_q == '0) begin
            fault_q <= 1'b1; state_q <= S_OUT;
          end else begin
            inv_q <= FIELD_BITS'(1); bit_q <= CntW'(FIELD_BITS);
            state_q <= S_INV_SQ;
          end
        end
        S_INV_SQ: begin
          if (bit_q == '0) begin
            ma_q <= num_q; mb_q <= inv_q;
            state_q <= S_LAMW;
          end else begin
            ma_q <= inv_q; mb_q <= inv_q;
            state_q <= S_INV_SQW;
          end
        end
        S_INV_SQW: if (rsp.done) begin
          inv_q <= prod;
          if (e_val[EW'(bit_q - 1'b1)]) begin
            ma_q <= prod; mb_q <= den_q;
            state_q <= S_INV_MLW;
          end else begin
            bit_q <= bit_q - 1'b1; state_q <= S_INV_SQ;
          end
        end
        S_INV_MLW: if (rsp.done) begin
          inv_q <= prod; bit_q <= bit_q - 1'b1; state_q <= S_INV_SQ;
        end
        S_LAMW: if (rsp.done) begin
          t_q <= prod; ma_q <= prod; mb_q <= prod;
          state_q <= S_LSQW;
        end
        S_LSQW: if (rsp.done) begin
          xr_q <= fsub(fsub(prod, p1x, m_q), p2x, m_q);
          ma_q <= t_q; mb_q <= fsub(p1x, fsub(fsub(prod, p1x, m_q), p2x, m_q), m_q);
          state_q <= S_YMW;
        end
        S_YMW: if (rsp.done) begin
          if (dbl_q) begin
            qx_q <= xr_q; qy_q <= fsub(prod, p1y, m_q);
          end else begin
            rx_q <= xr_q; ry_q <= fsub(prod, p1y, m_q);
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (res_inf_q) begin
            if (dbl_q) begin
              // q at infinity: later additions leave r unchanged.
              mag_q <= '0; state_q <= S_OUT;
            end else begin
              rinf_q <= 1'b1;
            end
          end
          res_inf_q <= 1'b0;
          if (!(res_inf_q && dbl_q)) begin
            if (!dbl_q) begin
              dbl_q <= 1'b1; state_q <= S_DBL;
            end else begin
              mag_q <= mag_q >> 1; state_q <= S_LOOP;
            end
          end
        end
        S_OUT: begin
          out_q.inverse_fault <= fault_q;
          out_q.result_at_infinity <= !fault_q && rinf_q;
          out_q.result_x <= (fault_q || rinf_q) ? '0 : rx_q;
          out_q.result_y <= (fault_q || rinf_q) ? '0 : ry_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign out_o     = out_q;
  assign coef_wr_o = (state_q == S_RED) && (red_cnt_q == 2'd1) && rsp.done;
  assign coef_a_o  = prod;
endmodule
